// File: rtl/assert_macros.svh
// Assertion helpers shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ILP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a condition that must hold on the edge after a trigger.
`define ILP_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: rtl/ilp_pkg.sv
package ilp_pkg;

    // Width of the result value field
    localparam int OUT_W = 32;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CASE_FOLD = 8'h20;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_ERROR  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_HEX = 2'd1,
        RX_BIN = 2'd2,
        RX_OCT = 2'd3
    } radix_t;

    // Character word leaving the input register
    typedef struct packed {
        logic       fire;
        logic [7:0] ch;
    } char_t;

    // Finished result word
    typedef struct packed {
        logic             valid;
        logic [OUT_W-1:0] value;
        logic             ok;
    } res_t;

endpackage

// File: rtl/ilp_in_stage.sv
module ilp_in_stage
    import ilp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       slot_free,
    output char_t      item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] ch_reg;
    logic       consume;

    // Drain the held word unless it is a terminator facing a full result slot
    assign consume  = valid_reg && ((ch_reg != CH_NUL) || slot_free);
    assign in_ready = !valid_reg || consume;

    assign item.fire = consume;
    assign item.ch   = ch_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the incoming word
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg <= ch;
        end
    end

endmodule

// File: rtl/ilp_parse.sv
module ilp_parse
    import ilp_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  char_t item,
    output res_t  res
);

`include "assert_macros.svh"

    phase_t                phase_reg;
    phase_t                phase_next;
    radix_t                radix_reg;
    radix_t                radix_next;
    logic                  negative_reg;
    logic                  negative_next;
    logic [VALUE_BITS-1:0] accum_reg;
    logic [VALUE_BITS-1:0] accum_next;

    logic [7:0]            folded;
    logic                  is_dec;
    logic                  is_af;
    logic [3:0]            digit;
    logic                  term;
    radix_t                eff_radix;
    logic                  digit_ok;
    logic [VALUE_BITS-1:0] scaled;
    logic [VALUE_BITS-1:0] stepped;
    logic [VALUE_BITS-1:0] signed_val;
    logic [OUT_W-1:0]      value_full;

    // Decode the character: fold lower case, pick out digit value
    assign term   = (item.ch == CH_NUL);
    assign folded = (item.ch >= CH_LA) ? (item.ch - CASE_FOLD) : item.ch;
    assign is_dec = (folded >= CH_ZERO) && (folded <= CH_NINE);
    assign is_af  = (folded >= CH_UA) && (folded <= CH_UF);
    assign digit  = is_dec ? folded[3:0] : (folded[3:0] + 4'd9);

    // Base in force for this character
    always_comb
    begin
        unique case (phase_reg)
            PH_LEAD, PH_SIGNED: eff_radix = RX_DEC;
            PH_ZERO:            eff_radix = RX_OCT;
            default:            eff_radix = radix_reg;
        endcase
    end

    always_comb
    begin
        unique case (eff_radix)
            RX_DEC: digit_ok = is_dec;
            RX_HEX: digit_ok = is_dec || is_af;
            RX_BIN: digit_ok = is_dec && (digit < 4'd2);
            RX_OCT: digit_ok = is_dec && (digit < 4'd8);
        endcase
    end

    // Scale the accumulator by the base and add the digit
    always_comb
    begin
        unique case (eff_radix)
            RX_DEC: scaled = (accum_reg << 3) + (accum_reg << 1);
            RX_HEX: scaled = accum_reg << 4;
            RX_BIN: scaled = accum_reg << 1;
            RX_OCT: scaled = accum_reg << 3;
        endcase
    end

    assign stepped = scaled + {{(VALUE_BITS-4){1'b0}}, digit};

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (item.fire)
        begin
            if (term)
            begin
                phase_next = PH_LEAD;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEAD:
                    begin
                        if (item.ch == CH_SPACE)
                            phase_next = PH_LEAD;
                        else if (item.ch == CH_MINUS || item.ch == CH_PLUS)
                            phase_next = PH_SIGNED;
                        else if (item.ch == CH_ZERO)
                            phase_next = PH_ZERO;
                        else
                            phase_next = digit_ok ? PH_DIGITS : PH_ERROR;
                    end
                    PH_SIGNED:
                    begin
                        if (item.ch == CH_ZERO)
                            phase_next = PH_ZERO;
                        else
                            phase_next = digit_ok ? PH_DIGITS : PH_ERROR;
                    end
                    PH_ZERO:
                    begin
                        if (folded == CH_UX || folded == CH_UB)
                            phase_next = PH_DIGITS;
                        else
                            phase_next = digit_ok ? PH_DIGITS : PH_ERROR;
                    end
                    PH_DIGITS:
                    begin
                        phase_next = digit_ok ? PH_DIGITS : PH_ERROR;
                    end
                    default:
                    begin
                        phase_next = PH_ERROR;
                    end
                endcase
            end
        end
    end

    // Datapath updates: radix, sign, accumulator
    always_comb
    begin
        radix_next    = radix_reg;
        negative_next = negative_reg;
        accum_next    = accum_reg;
        if (item.fire)
        begin
            if (term)
            begin
                radix_next    = RX_DEC;
                negative_next = 1'b0;
                accum_next    = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEAD, PH_SIGNED:
                    begin
                        if (phase_reg == PH_LEAD && item.ch == CH_MINUS)
                            negative_next = 1'b1;
                        else if (!(item.ch == CH_SPACE || item.ch == CH_PLUS ||
                                   item.ch == CH_MINUS || item.ch == CH_ZERO))
                        begin
                            radix_next = RX_DEC;
                            if (digit_ok)
                                accum_next = stepped;
                        end
                    end
                    PH_ZERO:
                    begin
                        if (folded == CH_UX)
                            radix_next = RX_HEX;
                        else if (folded == CH_UB)
                            radix_next = RX_BIN;
                        else
                        begin
                            radix_next = RX_OCT;
                            if (digit_ok)
                                accum_next = stepped;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (digit_ok)
                            accum_next = stepped;
                    end
                    default:
                    begin
                        accum_next = accum_reg;
                    end
                endcase
            end
        end
    end

    // Apply the sign and fit the result to the output width
    assign signed_val = negative_reg ? ({VALUE_BITS{1'b0}} - accum_reg) : accum_reg;

    generate
        if (VALUE_BITS >= OUT_W)
        begin : g_cut
            assign value_full = signed_val[OUT_W-1:0];
        end
        else
        begin : g_ext
            assign value_full = {{(OUT_W-VALUE_BITS){signed_val[VALUE_BITS-1]}}, signed_val};
        end
    endgenerate

    assign res.valid = item.fire && term;
    assign res.ok    = (phase_reg != PH_ERROR);
    assign res.value = (phase_reg != PH_ERROR) ? value_full : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LEAD;
            radix_reg    <= RX_DEC;
            negative_reg <= 1'b0;
            accum_reg    <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            radix_reg    <= radix_next;
            negative_reg <= negative_next;
            accum_reg    <= accum_next;
        end
    end

    `ILP_ASSERT(a_err_zero, (res.valid && !res.ok) |-> (res.value == '0), "error result not zero")
    `ILP_ASSERT_NEXT(a_term_clears, (item.fire && term), (phase_reg == PH_LEAD && accum_reg == '0 && !negative_reg), "state not cleared after terminator")
    `ILP_ASSERT_NEXT(a_err_sticky, (phase_reg == PH_ERROR && !(item.fire && term)), (phase_reg == PH_ERROR), "error phase left early")

endmodule

// File: rtl/ilp_out_stage.sv
module ilp_out_stage
    import ilp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  res_t             res,
    output logic             slot_free,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] value,
    output logic             ok
);

    logic             valid_reg;
    logic             valid_next;
    logic [OUT_W-1:0] value_reg;
    logic             ok_reg;

    // Slot opens when empty or being drained this cycle
    assign slot_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign value     = value_reg;
    assign ok        = ok_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res.valid)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the finished word
    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            value_reg <= res.value;
            ok_reg    <= res.ok;
        end
    end

endmodule

// File: rtl/integer_literal_parser.sv
// A terminator byte waits in the input register for a free result slot, and its result is then
// loaded into the output. One byte per cycle unless a terminator waits; at most one base-scaled add per digit.
// A result waiting in the output register does not block non-terminator bytes.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser
// to the leading-space phase, decimal, positive, accumulator zero.
module integer_literal_parser
    import ilp_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       ch,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] value,
    output logic             ok
);

`include "assert_macros.svh"

    char_t item;
    res_t  res;
    logic  slot_free;

    ilp_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .slot_free (slot_free),
        .item      (item)
    );

    ilp_parse #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .res   (res)
    );

    ilp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .ok        (ok)
    );

    `ILP_ASSERT(a_no_overwrite, res.valid |-> (!out_valid || out_ready), "result slot overwritten")

endmodule
